// ===== design/gtr_pkg.sv =====
// grid ray traversal package: field widths, register map, opcodes and controller states
// used by the top level, the port checker and the testbench
`default_nettype none
package gtr_pkg;
	localparam int CFG_W   = 7;
	localparam int COORD_W = 6;
	localparam int VALUE_W = 8;
	localparam int DIST_W  = 32;
	localparam int STEP_W  = 2;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// register index as decoded from paddr[2]
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK
	} gtr_state_t;
endpackage
`default_nettype wire

// ===== design/gtr_ram.sv =====
// generic single-clock ram: one write port, one read port, registered read data
// no dependencies
`default_nettype none
module gtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/grid_ray_traversal.sv =====
// grid ray traversal top level: map storage, dda walk controller, apb register file
// depends on gtr_pkg and gtr_ram
`default_nettype none
// After reset the block clears all GRID_DIM*GRID_DIM cells of the map ram one cell
// per cycle, with busy high; register writes are taken during the clear. A write
// item leaves busy low. A cast item walks one DDA step per cycle, each step that
// does not end the walk issuing one read of the single map read port, and the wall
// test of a step overlaps the next step; a cast that starts outside the grid is
// answered without a walk. done is a one-cycle pulse: the user is to take the
// result that cycle; the result outputs hold until the next cast is accepted.
// A new item may be started in the cycle that done is high.
module grid_ray_traversal #(
	parameter int GRID_DIM = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gtr_pkg::APB_AW-1:0]   paddr,
	input  wire logic [gtr_pkg::APB_DW-1:0]   pwdata,
	output logic      [gtr_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         operation,
	input  wire logic [gtr_pkg::COORD_W-1:0]  cell_x,
	input  wire logic [gtr_pkg::COORD_W-1:0]  cell_y,
	input  wire logic [gtr_pkg::VALUE_W-1:0]  cell_value,
	input  wire logic [gtr_pkg::DIST_W-1:0]   start_side_x,
	input  wire logic [gtr_pkg::DIST_W-1:0]   start_side_y,
	input  wire logic [gtr_pkg::DIST_W-1:0]   delta_x,
	input  wire logic [gtr_pkg::DIST_W-1:0]   delta_y,
	input  wire logic signed [gtr_pkg::STEP_W-1:0] step_x,
	input  wire logic signed [gtr_pkg::STEP_W-1:0] step_y,
	output logic                              done,
	output logic      [gtr_pkg::COORD_W-1:0]  hit_x,
	output logic      [gtr_pkg::COORD_W-1:0]  hit_y,
	output logic      [gtr_pkg::VALUE_W-1:0]  wall_value,
	output logic                              side_hit,
	output logic      [gtr_pkg::DIST_W-1:0]   final_side_x,
	output logic      [gtr_pkg::DIST_W-1:0]   final_side_y,
	output logic                              found_wall
);
	import gtr_pkg::*;

	localparam int LW    = $clog2(GRID_DIM);
	// signed coordinate wide enough for 6-bit start cells, the grid and one step past it
	localparam int XW    = ((LW > COORD_W) ? LW : COORD_W) + 2;
	localparam int DEPTH = GRID_DIM * GRID_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(2 * GRID_DIM + 1);
	localparam logic signed [XW-1:0] GDIM      = XW'(GRID_DIM);
	localparam logic [NW-1:0]        STEP_MAX  = NW'(2 * GRID_DIM);
	localparam logic [AW-1:0]        CLR_LAST  = AW'(DEPTH - 1);
	localparam logic [AW-1:0]        ROW_PITCH = AW'(GRID_DIM);

	gtr_state_t state_q, state_d;

	logic [AW-1:0]    clr_q;
	logic [CFG_W-1:0] width_q, height_q;
	logic             done_q;
	logic             pend_q;
	logic [NW-1:0]    cnt_q;

	logic signed [XW-1:0]     cur_x_q, cur_y_q;
	logic [DIST_W-1:0]        side_x_q, side_y_q, dx_q, dy_q;
	logic signed [STEP_W-1:0] sx_q, sy_q;
	logic                     side_q;

	logic [COORD_W-1:0] hit_x_q, hit_y_q;
	logic [VALUE_W-1:0] wall_value_q;
	logic               side_hit_q, found_q;
	logic [DIST_W-1:0]  fin_x_q, fin_y_q;

	// map ram
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;

	gtr_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// apb register file
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = APB_DW'(width_q);
			REG_GRID_HEIGHT: prdata = APB_DW'(height_q);
			default:         prdata = '0;
		endcase
	end

	// effective grid size, clamped to storage
	logic signed [XW-1:0] w_raw, h_raw, w_eff, h_eff;
	assign w_raw = $signed(XW'(width_q));
	assign h_raw = $signed(XW'(height_q));
	assign w_eff = (w_raw > GDIM) ? GDIM : w_raw;
	assign h_eff = (h_raw > GDIM) ? GDIM : h_raw;

	// input side
	logic                 accept, start_in, in_store;
	logic signed [XW-1:0] in_x, in_y;
	assign accept   = start && (state_q == ST_IDLE);
	assign in_x     = $signed(XW'(cell_x));
	assign in_y     = $signed(XW'(cell_y));
	assign start_in = (in_x < w_eff) && (in_y < h_eff);
	assign in_store = (in_x < GDIM) && (in_y < GDIM);

	// one dda step from the current cell
	logic                 go_x, hit_now, at_limit, leaves, finish;
	logic [DIST_W:0]      sum_x, sum_y;
	logic [DIST_W-1:0]    nside_x, nside_y;
	logic signed [XW-1:0] sx_ext, sy_ext, nx, ny;

	always_comb begin
		go_x    = side_x_q < side_y_q;
		sum_x   = {1'b0, side_x_q} + {1'b0, dx_q};
		sum_y   = {1'b0, side_y_q} + {1'b0, dy_q};
		sx_ext  = $signed({{(XW-STEP_W){sx_q[STEP_W-1]}}, sx_q});
		sy_ext  = $signed({{(XW-STEP_W){sy_q[STEP_W-1]}}, sy_q});
		nside_x = side_x_q;
		nside_y = side_y_q;
		nx      = cur_x_q;
		ny      = cur_y_q;
		if (go_x) begin
			nside_x = sum_x[DIST_W] ? '1 : sum_x[DIST_W-1:0];
			nx      = cur_x_q + sx_ext;
		end else begin
			nside_y = sum_y[DIST_W] ? '1 : sum_y[DIST_W-1:0];
			ny      = cur_y_q + sy_ext;
		end
		leaves   = (nx < 0) || (nx >= w_eff) || (ny < 0) || (ny >= h_eff);
		// read data belongs to the cell we are standing on
		hit_now  = pend_q && (mem_rdata != '0);
		at_limit = cnt_q == STEP_MAX;
		finish   = hit_now || at_limit || leaves;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && operation == OP_CAST && start_in) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory control and status outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = AW'(AW'($unsigned(ny)) * ROW_PITCH + AW'($unsigned(nx)));
		busy      = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				busy      = 1'b0;
				mem_we    = accept && operation == OP_WRITE && in_store;
				mem_waddr = AW'(AW'($unsigned(in_y)) * ROW_PITCH + AW'($unsigned(in_x)));
				mem_wdata = cell_value;
			end
			ST_WALK: begin
				mem_re = !finish;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
			done_q   <= 1'b0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_wr) begin
				case (paddr[2])
					REG_GRID_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
					REG_GRID_HEIGHT: height_q <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept && operation == OP_CAST) begin
				pend_q <= 1'b0;
				cnt_q  <= '0;
				done_q <= !start_in;
			end
			if (state_q == ST_WALK) begin
				if (finish) begin
					done_q <= 1'b1;
					pend_q <= 1'b0;
				end else begin
					pend_q <= 1'b1;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		if (accept && operation == OP_CAST) begin
			cur_x_q  <= in_x;
			cur_y_q  <= in_y;
			side_x_q <= start_side_x;
			side_y_q <= start_side_y;
			dx_q     <= delta_x;
			dy_q     <= delta_y;
			sx_q     <= step_x;
			sy_q     <= step_y;
			side_q   <= 1'b0;
			// result preset on every cast; a start outside the grid is answered with it at once
			hit_x_q      <= cell_x;
			hit_y_q      <= cell_y;
			wall_value_q <= '0;
			side_hit_q   <= 1'b0;
			fin_x_q      <= start_side_x;
			fin_y_q      <= start_side_y;
			found_q      <= 1'b0;
		end
		if (state_q == ST_WALK) begin
			hit_x_q <= cur_x_q[COORD_W-1:0];
			hit_y_q <= cur_y_q[COORD_W-1:0];
			if (hit_now) begin
				wall_value_q <= mem_rdata;
				side_hit_q   <= side_q;
				fin_x_q      <= side_x_q;
				fin_y_q      <= side_y_q;
				found_q      <= 1'b1;
			end else if (at_limit) begin
				wall_value_q <= '0;
				side_hit_q   <= side_q;
				fin_x_q      <= side_x_q;
				fin_y_q      <= side_y_q;
				found_q      <= 1'b0;
			end else if (leaves) begin
				// the step that left still counts in side and distances
				wall_value_q <= '0;
				side_hit_q   <= !go_x;
				fin_x_q      <= nside_x;
				fin_y_q      <= nside_y;
				found_q      <= 1'b0;
			end else begin
				cur_x_q  <= nx;
				cur_y_q  <= ny;
				side_x_q <= nside_x;
				side_y_q <= nside_y;
				side_q   <= !go_x;
			end
		end
	end

	assign done         = done_q;
	assign hit_x        = hit_x_q;
	assign hit_y        = hit_y_q;
	assign wall_value   = wall_value_q;
	assign side_hit     = side_hit_q;
	assign final_side_x = fin_x_q;
	assign final_side_y = fin_y_q;
	assign found_wall   = found_q;
endmodule
`default_nettype wire

// ===== design/gtr_checker.sv =====
// port-level checker for grid_ray_traversal, attached by the bind at the end
// depends on gtr_pkg
`default_nettype none
module gtr_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        operation,
	input wire logic                        done,
	input wire logic [gtr_pkg::VALUE_W-1:0] wall_value,
	input wire logic                        found_wall
);
	import gtr_pkg::*;

	// a result only follows a cast beat or a walk in progress
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy && operation == OP_CAST)))
		else $error("result without a cast");

	// a map write beat yields no result and leaves the block ready
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_WRITE) |=> (!done && !busy))
		else $error("write beat produced a result or went busy");

	a_found_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_wall) |-> (wall_value != '0))
		else $error("wall found with zero value");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found_wall) |-> (wall_value == '0))
		else $error("miss with nonzero wall value");
endmodule

bind grid_ray_traversal gtr_checker u_gtr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.operation  (operation),
	.done       (done),
	.wall_value (wall_value),
	.found_wall (found_wall)
);
`default_nettype wire

// ===== tb/grid_ray_traversal_tb.sv =====
// self-checking testbench for grid_ray_traversal: map writes, dda casts and apb registers
// needs gtr_pkg and the grid_ray_traversal rtl; predicts every cast result internally
module grid_ray_traversal_tb;
	import gtr_pkg::*;

	localparam int GRID_DIM     = 64;
	localparam int DRAIN_CYCLES = 2 * GRID_DIM + 8;

	localparam logic [1:0] STEP_POS  = 2'b01;
	localparam logic [1:0] STEP_NEG  = 2'b11;
	localparam logic [1:0] STEP_STAY = 2'b00;
	localparam logic [1:0] STEP_NEG2 = 2'b10;

	typedef struct packed {
		logic              op;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [VALUE_W-1:0] val;
		logic [DIST_W-1:0]  sdx;
		logic [DIST_W-1:0]  sdy;
		logic [DIST_W-1:0]  ddx;
		logic [DIST_W-1:0]  ddy;
		logic [STEP_W-1:0]  stx;
		logic [STEP_W-1:0]  sty;
	} ray_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] hx;
		logic [COORD_W-1:0] hy;
		logic [VALUE_W-1:0] wall;
		logic               side;
		logic [DIST_W-1:0]  acc_x;
		logic [DIST_W-1:0]  acc_y;
		logic               found;
	} ray_hit_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [APB_AW-1:0]          paddr = '0;
	logic [APB_DW-1:0]          pwdata = '0;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       operation = 1'b0;
	logic [COORD_W-1:0]         cell_x = '0;
	logic [COORD_W-1:0]         cell_y = '0;
	logic [VALUE_W-1:0]         cell_value = '0;
	logic [DIST_W-1:0]          start_side_x = '0;
	logic [DIST_W-1:0]          start_side_y = '0;
	logic [DIST_W-1:0]          delta_x = '0;
	logic [DIST_W-1:0]          delta_y = '0;
	logic signed [STEP_W-1:0]   step_x = '0;
	logic signed [STEP_W-1:0]   step_y = '0;
	logic                       done;
	logic [COORD_W-1:0]         hit_x;
	logic [COORD_W-1:0]         hit_y;
	logic [VALUE_W-1:0]         wall_value;
	logic                       side_hit;
	logic [DIST_W-1:0]          final_side_x;
	logic [DIST_W-1:0]          final_side_y;
	logic                       found_wall;

	logic [VALUE_W-1:0] map_model [0:GRID_DIM*GRID_DIM-1];
	logic [CFG_W-1:0]   cfg_width = CFG_RESET;
	logic [CFG_W-1:0]   cfg_height = CFG_RESET;
	ray_hit_t           pending_hits [$];

	int err_count = 0;
	int casts_sent = 0;
	int writes_sent = 0;
	int hits_seen = 0;
	int results_seen = 0;
	int cfg_writes = 0;

	grid_ray_traversal #(.GRID_DIM(GRID_DIM)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .operation(operation),
		.cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value),
		.start_side_x(start_side_x), .start_side_y(start_side_y),
		.delta_x(delta_x), .delta_y(delta_y),
		.step_x(step_x), .step_y(step_y),
		.done(done), .hit_x(hit_x), .hit_y(hit_y), .wall_value(wall_value),
		.side_hit(side_hit), .final_side_x(final_side_x), .final_side_y(final_side_y),
		.found_wall(found_wall)
	);

	always #4 clk = ~clk;

	function automatic int clamp_dim(logic [CFG_W-1:0] r);
		return (r > GRID_DIM) ? GRID_DIM : int'(r);
	endfunction

	function automatic logic [DIST_W-1:0] sat_add32(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? '1 : s[DIST_W-1:0];
	endfunction

	// dda walk on the map model with the current register settings
	function automatic ray_hit_t trace_ray(ray_cmd_t c);
		int x, y, w, h, sx, sy, nx, ny;
		logic [DIST_W-1:0] acc_x, acc_y;
		logic [VALUE_W-1:0] val;
		logic side, found, stop;
		ray_hit_t r;
		x = int'(c.cx);
		y = int'(c.cy);
		acc_x = c.sdx;
		acc_y = c.sdy;
		sx = int'($signed(c.stx));
		sy = int'($signed(c.sty));
		w = clamp_dim(cfg_width);
		h = clamp_dim(cfg_height);
		val = '0;
		side = 1'b0;
		found = 1'b0;
		stop = 1'b0;
		if (x < w && y < h) begin
			for (int n = 0; n < 2 * GRID_DIM && !stop; n++) begin
				nx = x;
				ny = y;
				if (acc_x < acc_y) begin
					acc_x = sat_add32(acc_x, c.ddx);
					nx = x + sx;
					side = 1'b0;
				end else begin
					acc_y = sat_add32(acc_y, c.ddy);
					ny = y + sy;
					side = 1'b1;
				end
				if (nx < 0 || nx >= w || ny < 0 || ny >= h) begin
					stop = 1'b1;
				end else begin
					x = nx;
					y = ny;
					val = map_model[{y[COORD_W-1:0], x[COORD_W-1:0]}];
					if (val != 0) begin
						found = 1'b1;
						stop = 1'b1;
					end
				end
			end
		end
		r.hx = x[COORD_W-1:0];
		r.hy = y[COORD_W-1:0];
		r.wall = found ? val : '0;
		r.side = side;
		r.acc_x = acc_x;
		r.acc_y = acc_y;
		r.found = found;
		return r;
	endfunction

	function automatic ray_cmd_t mk_write(int x, int y, logic [VALUE_W-1:0] v);
		ray_cmd_t c;
		c = '0;
		c.op = OP_WRITE;
		c.cx = x[COORD_W-1:0];
		c.cy = y[COORD_W-1:0];
		c.val = v;
		return c;
	endfunction

	function automatic ray_cmd_t mk_cast(int x, int y, logic [DIST_W-1:0] sdx,
			logic [DIST_W-1:0] sdy, logic [DIST_W-1:0] ddx, logic [DIST_W-1:0] ddy,
			logic [STEP_W-1:0] stx, logic [STEP_W-1:0] sty);
		ray_cmd_t c;
		c.op = OP_CAST;
		c.cx = x[COORD_W-1:0];
		c.cy = y[COORD_W-1:0];
		c.val = '0;
		c.sdx = sdx;
		c.sdy = sdy;
		c.ddx = ddx;
		c.ddy = ddy;
		c.stx = stx;
		c.sty = sty;
		return c;
	endfunction

	// mostly inside the area in use, now and then anywhere in the map
	function automatic logic [COORD_W-1:0] pick_coord(int lim);
		if (lim == 0 || $urandom_range(0, 9) == 0)
			return COORD_W'($urandom_range(0, GRID_DIM - 1));
		return COORD_W'($urandom_range(0, lim - 1));
	endfunction

	function automatic ray_cmd_t make_random_cmd();
		ray_cmd_t c;
		int kind;
		kind = $urandom_range(0, 99);
		c.op = OP_CAST;
		c.cx = pick_coord(clamp_dim(cfg_width));
		c.cy = pick_coord(clamp_dim(cfg_height));
		c.val = VALUE_W'($urandom);
		c.sdx = $urandom;
		c.sdy = $urandom;
		c.ddx = $urandom;
		c.ddy = $urandom;
		c.stx = STEP_W'($urandom);
		c.sty = STEP_W'($urandom);
		if (kind < 35) begin
			c.op = OP_WRITE;
			if ($urandom_range(0, 4) == 0)
				c.val = '0;
		end else if (kind < 85) begin
			// plausible ray: unit steps, side distance within one delta
			c.ddx = ($urandom_range(0, 15) == 0) ? '1 : $urandom_range(32'h4000, 32'h8_0000);
			c.ddy = ($urandom_range(0, 15) == 0) ? '1 : $urandom_range(32'h4000, 32'h8_0000);
			c.sdx = $urandom_range(0, c.ddx);
			c.sdy = $urandom_range(0, c.ddy);
			c.stx = $urandom_range(0, 1) ? STEP_POS : STEP_NEG;
			c.sty = $urandom_range(0, 1) ? STEP_POS : STEP_NEG;
		end
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic idle_for(int n);
		if (n > 0) begin
			@(negedge clk) start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// present one item and hold it until the block takes it
	task automatic send_cmd(ray_cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		operation <= c.op;
		cell_x <= c.cx;
		cell_y <= c.cy;
		cell_value <= c.val;
		start_side_x <= c.sdx;
		start_side_y <= c.sdy;
		delta_x <= c.ddx;
		delta_y <= c.ddy;
		step_x <= c.stx;
		step_y <= c.sty;
		do @(posedge clk); while (busy);
		if (c.op == OP_CAST) begin
			pending_hits.push_back(trace_ray(c));
			casts_sent++;
		end else begin
			map_model[{c.cy, c.cx}] = c.val;
			writes_sent++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk) start <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// apb write followed by a read back of the same register
	task automatic cfg_set(logic idx, logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] word;
		wait_idle();
		word = $urandom;
		word[CFG_W-1:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_GRID_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
		cfg_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(APB_DW-CFG_W){1'b0}}, value}) begin
			err_count++;
			$display("%0t: register %0d read back, expected %h, got %h",
				$time, idx, {{(APB_DW-CFG_W){1'b0}}, value}, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		ray_hit_t want;
		if (arst_n && done) begin
			results_seen++;
			if (found_wall === 1'b1)
				hits_seen++;
			if (pending_hits.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, got hit (%0d,%0d)",
					$time, hit_x, hit_y);
			end else begin
				want = pending_hits.pop_front();
				check_field("hit_x", DIST_W'(want.hx), DIST_W'(hit_x));
				check_field("hit_y", DIST_W'(want.hy), DIST_W'(hit_y));
				check_field("wall_value", DIST_W'(want.wall), DIST_W'(wall_value));
				check_field("side_hit", DIST_W'(want.side), DIST_W'(side_hit));
				check_field("final_side_x", want.acc_x, final_side_x);
				check_field("final_side_y", want.acc_y, final_side_y);
				check_field("found_wall", DIST_W'(want.found), DIST_W'(found_wall));
			end
		end
	end

	task automatic test_register_access();
		cfg_set(REG_GRID_WIDTH, 7'd0);
		cfg_set(REG_GRID_HEIGHT, 7'd127);
		cfg_set(REG_GRID_WIDTH, 7'd64);
		cfg_set(REG_GRID_HEIGHT, 7'd64);
	endtask

	task automatic test_directed_walks();
		// empty map: the ray runs off the edge
		send_cmd(mk_cast(32, 32, 32'h8000, 32'hC000, 32'h1_0000, 32'h1_8000, STEP_POS, STEP_POS));
		send_cmd(mk_write(40, 32, 8'hFF));
		send_cmd(mk_cast(32, 32, 32'h0, 32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_NEG));
		// start on a wall: the start cell is skipped
		send_cmd(mk_cast(40, 32, 32'h0, 32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000, STEP_NEG, STEP_POS));
		send_cmd(mk_write(0, 0, 8'h01));
		send_cmd(mk_write(63, 63, 8'h80));
		// tied side distances step along y first
		send_cmd(mk_cast(62, 62, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		// saturating accumulators
		send_cmd(mk_cast(0, 10, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
			STEP_POS, STEP_POS));
		// zero step never moves, walk ends on the step limit
		send_cmd(mk_cast(5, 5, 32'h0, 32'h1, 32'h0, 32'h0, STEP_STAY, STEP_STAY));
		send_cmd(mk_write(10, 0, 8'h33));
		// step code of minus two skips every other column
		send_cmd(mk_cast(20, 0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h1, STEP_NEG2, STEP_POS));
		send_cmd(mk_cast(3, 0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h2_0000, STEP_POS, STEP_NEG));
		send_cmd(mk_write(0, 0, 8'h00));
		send_cmd(mk_cast(4, 4, 32'h8000, 32'h8000, 32'h1_0000, 32'h1_0000, STEP_NEG, STEP_NEG));
		idle_for(1);
	endtask

	task automatic test_grid_bounds();
		cfg_set(REG_GRID_WIDTH, 7'd1);
		cfg_set(REG_GRID_HEIGHT, 7'd1);
		send_cmd(mk_cast(0, 0, 32'h4000, 32'h8000, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		send_cmd(mk_cast(1, 0, 32'h4000, 32'h8000, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		send_cmd(mk_cast(0, 1, 32'h4000, 32'h8000, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		cfg_set(REG_GRID_WIDTH, 7'd0);
		send_cmd(mk_cast(0, 0, 32'h1, 32'h2, 32'h3, 32'h4, STEP_POS, STEP_POS));
		cfg_set(REG_GRID_WIDTH, 7'd8);
		cfg_set(REG_GRID_HEIGHT, 7'd4);
		// write past the width in use is still kept
		send_cmd(mk_write(10, 2, 8'h05));
		send_cmd(mk_cast(0, 2, 32'h0, 32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		cfg_set(REG_GRID_WIDTH, 7'd127);
		cfg_set(REG_GRID_HEIGHT, 7'd127);
		send_cmd(mk_cast(0, 2, 32'h0, 32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		send_cmd(mk_cast(63, 62, 32'h0, 32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000, STEP_POS, STEP_POS));
		cfg_set(REG_GRID_HEIGHT, 7'd0);
		send_cmd(mk_cast(0, 0, 32'h1, 32'h0, 32'h3, 32'h4, STEP_NEG, STEP_NEG));
	endtask

	task automatic test_random_traffic();
		int ph_w [9] = '{64, 16, 1, 64, 127, 0, 5, 0, 0};
		int ph_h [9] = '{64, 12, 64, 1, 90, 7, 0, 0, 0};
		int ph_n [9] = '{200, 150, 60, 60, 150, 30, 30, 110, 110};
		bit no_idle;
		ph_w[7] = $urandom_range(1, 64);
		ph_h[7] = $urandom_range(1, 64);
		ph_w[8] = $urandom_range(2, 64);
		ph_h[8] = $urandom_range(65, 127);
		for (int p = 0; p < 9; p++) begin
			cfg_set(REG_GRID_WIDTH, ph_w[p][CFG_W-1:0]);
			cfg_set(REG_GRID_HEIGHT, ph_h[p][CFG_W-1:0]);
			no_idle = 1'b0;
			for (int i = 0; i < ph_n[p]; i++) begin
				if (i % 40 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				send_cmd(make_random_cmd());
				if (!no_idle)
					idle_for(pick_gap());
			end
		end
	endtask

	initial begin
		int guard;
		foreach (map_model[i])
			map_model[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		// map clear pass after reset
		do @(posedge clk); while (busy);
		test_register_access();
		test_directed_walks();
		test_grid_bounds();
		test_random_traffic();
		@(negedge clk) start <= 1'b0;
		guard = 0;
		while (pending_hits.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_hits.size() != 0) begin
			err_count++;
			$display("%0t: results missing, expected %0d more, got none",
				$time, pending_hits.size());
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d casts (%0d walls hit), %0d map writes, %0d register writes",
			casts_sent, hits_seen, writes_sent, cfg_writes);
		$display("results checked: %0d, errors: %0d", results_seen, err_count);
		if (err_count == 0)
			$display("grid_ray_traversal_tb OK");
		else
			$display("grid_ray_traversal_tb NOT OK");
		$finish;
	end

	initial begin
		#8000000;
		$display("timeout with %0d results outstanding", pending_hits.size());
		$display("grid_ray_traversal_tb NOT OK");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/gtr_pkg.sv
design/gtr_ram.sv
design/grid_ray_traversal.sv
design/gtr_checker.sv
tb/grid_ray_traversal_tb.sv
